// ===== rtl/sshm_pkg.sv =====
// Shared types, constants and helpers for the gyro sample health monitor.
// No dependencies; imported by every other module of the block.
`timescale 1ns / 1ps

package sshm_pkg;

  // Counter width of all saturating totals
  localparam int COUNT_BITS = 16;

  localparam int AXES      = 3;
  localparam int AXIS_W    = 16;
  localparam int SUM_W     = COUNT_BITS + AXIS_W + 1;   // signed axis sum
  localparam int ABS_W     = SUM_W - 1;                 // magnitude of a sum
  localparam int DIV_CNT_W = $clog2(ABS_W + 1);
  localparam int OUT_CMP_W = COUNT_BITS + 16;

  localparam int IN_DATA_W  = 48;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 128;
  localparam int OUT_USER_W = 3;
  localparam int CFG_DATA_W = 16;

  typedef logic [1:0] axis_idx_t;
  localparam axis_idx_t AXIS_X    = 2'd0;
  localparam axis_idx_t AXIS_Y    = 2'd1;
  localparam axis_idx_t AXIS_LAST = 2'd2;

  // Input request kind
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_REPORT = 1'b1;

  // Result kind
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  // Register indexes
  typedef logic reg_idx_t;
  localparam reg_idx_t REG_NOISE_MIN = 1'b0;
  localparam reg_idx_t REG_NOISE_MAX = 1'b1;

  // Noise classes
  localparam logic [1:0] CLS_NORMAL = 2'd0;
  localparam logic [1:0] CLS_QUIET  = 2'd1;
  localparam logic [1:0] CLS_NOISY  = 2'd2;
  localparam logic [1:0] CLS_EMPTY  = 2'd3;

  // Flag bit positions
  localparam int FLG_FAILED      = 0;
  localparam int FLG_ALLZERO     = 1;
  localparam int FLG_ALLONES     = 2;
  localparam int FLG_FROZEN      = 3;
  localparam int FLG_FAILSTART   = 4;
  localparam int FLG_RECOVERED   = 5;
  localparam int FLG_FROZENSTART = 6;
  localparam int FLG_UNFROZEN    = 7;

  typedef struct packed {
    logic      load_in;      // capture the input request
    logic      do_sample;    // apply a sample and load its status
    logic      div_start;    // start the mean division for axis
    logic      emit_report;  // load the report result for axis
    axis_idx_t axis;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;   // output register can take a result this cycle
    logic no_good;    // no good sample counted yet
    logic div_done;   // quotient ready
  } dp_sts_t;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
    return (&c) ? c : c + COUNT_BITS'(1);
  endfunction

  // Clamp a count to the 16-bit report field
  function automatic logic [15:0] out16(input logic [COUNT_BITS-1:0] c);
    logic [OUT_CMP_W-1:0] wide;
    wide = OUT_CMP_W'(c);
    return (wide > OUT_CMP_W'(16'hFFFF)) ? 16'hFFFF : wide[15:0];
  endfunction

endpackage

// ===== rtl/sensor_sample_health_monitor_unit.sv =====
// Top level of the gyro sample health monitor.
// Depends on sshm_pkg, sshm_ctrl, sshm_dp (which holds sshm_div).
`timescale 1ns / 1ps

//  channel | dir | handshake            | payload
//  --------+-----+----------------------+-----------------------------------------
//  in_     | in  | in_tvalid/in_tready  | tuser: cmd, read_ok; tdata: x, y, z
//  out_    | out | out_tvalid/out_tready| tuser: kind, item; tlast: last; tdata
//  cfg_    | in  | cfg_valid/cfg_ready  | cfg_index (0 noise_min, 1 noise_max)
//
// Sample request: capture, then flag/total update into the output reg once it is free.
// Report request: 3 results; per axis one launch of the bit-serial mean divider
//   (skipped while no good sample is counted) and one load.
// A new request is taken while the previous result still sits in the output reg;
//   out_tready low stalls only the next result load.
// rst_n is synchronous, active low; config writes are always ready.
// Reports leave all totals untouched.

module sensor_sample_health_monitor_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // request channel
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [sshm_pkg::IN_DATA_W-1:0]       in_tdata,   // axis_x, axis_y, axis_z
  input  logic [sshm_pkg::IN_USER_W-1:0]       in_tuser,   // cmd, read_ok
  // result channel
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // flags, mean, min_value, max_value, spread, noise_class,
  // ok_count, fail_count, bad_count, zero pad
  output logic [sshm_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic [sshm_pkg::OUT_USER_W-1:0]      out_tuser,  // kind, item[1:0]
  output logic                                 out_tlast,
  // config write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  sshm_pkg::reg_idx_t                   cfg_index,
  input  logic [sshm_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import sshm_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  // register writes are never back-pressured
  assign cfg_ready = 1'b1;

  sshm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_cmd    (in_tuser[0]),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sshm_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

// ===== rtl/sshm_div.sv =====
// Restoring divider, one quotient bit per cycle, for the per-axis mean.
// Depends on sshm_pkg.
`timescale 1ns / 1ps

module sshm_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [sshm_pkg::ABS_W-1:0]       dividend,
  input  logic [sshm_pkg::COUNT_BITS-1:0]  divisor,
  output logic                             done,
  output logic [sshm_pkg::ABS_W-1:0]       quotient
);
  import sshm_pkg::*;

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [COUNT_BITS-1:0] rem_r, rem_nxt;
  logic [COUNT_BITS-1:0] div_r, div_nxt;
  logic [ABS_W-1:0]      quo_r, quo_nxt;

  logic [COUNT_BITS:0]   trial;
  logic [COUNT_BITS:0]   diff;
  logic                  ge;

  assign trial = {rem_r, quo_r[ABS_W-1]};
  assign diff  = trial - {1'b0, div_r};
  assign ge    = trial >= {1'b0, div_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      div_nxt  = divisor;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
      quo_nxt = {quo_r[ABS_W-2:0], ge};
      cnt_nxt = cnt_r + DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(ABS_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    div_r <= div_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider restarted while busy");

  a_divisor_nz: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> divisor != '0)
    else $error("divider started with zero divisor");

endmodule

// ===== rtl/sshm_ctrl.sv =====
// Sequencer of the health monitor: request intake, sample update, report walk.
// Depends on sshm_pkg; drives sshm_dp through ctrl_cmd_t.
`timescale 1ns / 1ps

module sshm_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_cmd,
  output logic                 in_tready,
  input  sshm_pkg::dp_sts_t    sts,
  output sshm_pkg::ctrl_cmd_t  cmd
);
  import sshm_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_SAMPLE   = 5'b00010,
    ST_DIV_GO   = 5'b00100,
    ST_DIV_WAIT = 5'b01000,
    ST_EMIT     = 5'b10000
  } state_t;

  state_t    state_r, state_nxt;
  axis_idx_t axis_r, axis_nxt;

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt       = state_r;
    axis_nxt        = axis_r;
    cmd.load_in     = 1'b0;
    cmd.do_sample   = 1'b0;
    cmd.div_start   = 1'b0;
    cmd.emit_report = 1'b0;
    cmd.axis        = axis_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          axis_nxt    = AXIS_X;
          state_nxt   = (in_cmd == CMD_REPORT) ? ST_DIV_GO : ST_SAMPLE;
        end
      end
      ST_SAMPLE: begin
        if (sts.out_free) begin
          cmd.do_sample = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_DIV_GO: begin
        if (sts.no_good) begin
          state_nxt = ST_EMIT;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV_WAIT;
        end
      end
      ST_DIV_WAIT: begin
        if (sts.div_done) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_report = 1'b1;
          if (axis_r == AXIS_LAST) begin
            state_nxt = ST_IDLE;
          end else begin
            axis_nxt  = axis_r + 2'd1;
            state_nxt = ST_DIV_GO;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      axis_r  <= AXIS_X;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
    end
  end

  a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.do_sample || cmd.emit_report) |-> sts.out_free)
    else $error("result loaded while output register busy");

endmodule

// ===== rtl/sshm_dp.sv =====
// Datapath of the health monitor: input capture, totals, per-axis stats,
// flag logic, report fields and output register. Depends on sshm_pkg, sshm_div.
`timescale 1ns / 1ps

module sshm_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [sshm_pkg::IN_DATA_W-1:0]       in_tdata,
  input  logic [sshm_pkg::IN_USER_W-1:0]       in_tuser,
  input  logic                                 cfg_valid,
  input  sshm_pkg::reg_idx_t                   cfg_index,
  input  logic [sshm_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [sshm_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic [sshm_pkg::OUT_USER_W-1:0]      out_tuser,
  output logic                                 out_tlast,
  input  sshm_pkg::ctrl_cmd_t                  cmd,
  output sshm_pkg::dp_sts_t                    sts
);
  import sshm_pkg::*;

  // captured request
  logic                 read_ok_r;
  logic [IN_DATA_W-1:0] sample_r;

  // configuration
  logic [15:0] noise_min_r, noise_max_r;

  // totals
  logic [COUNT_BITS-1:0] good_r, good_nxt;
  logic [COUNT_BITS-1:0] failed_r, failed_nxt;
  logic [COUNT_BITS-1:0] zero_r, zero_nxt;
  logic [COUNT_BITS-1:0] ones_r, ones_nxt;
  logic [COUNT_BITS-1:0] stale_r, stale_nxt;

  logic signed [SUM_W-1:0]  sum_r [AXES];
  logic signed [SUM_W-1:0]  sum_nxt [AXES];
  logic signed [AXIS_W-1:0] min_r [AXES];
  logic signed [AXIS_W-1:0] min_nxt [AXES];
  logic signed [AXIS_W-1:0] max_r [AXES];
  logic signed [AXIS_W-1:0] max_nxt [AXES];

  logic [IN_DATA_W-1:0] prev_r, prev_nxt;
  logic                 have_prev_r, have_prev_nxt;
  logic                 failing_r, failing_nxt;
  logic                 frozen_r, frozen_nxt;
  logic [7:0]           flags_s;

  // output register
  logic                 out_valid_r;
  logic                 out_kind_r;
  logic [1:0]           out_item_r;
  logic                 out_last_r;
  logic [7:0]           out_flags_r;
  logic [15:0]          out_mean_r, out_min_r, out_max_r, out_spread_r;
  logic [1:0]           out_cls_r;
  logic [15:0]          out_ok_r, out_fail_r, out_bad_r;

  // report side
  logic signed [SUM_W-1:0]  sel_sum;
  logic signed [AXIS_W-1:0] sel_min, sel_max;
  logic                     sum_neg;
  logic [SUM_W-1:0]         sum_mag;
  logic                     div_done;
  logic [ABS_W-1:0]         quotient;
  logic [AXIS_W-1:0]        q16, mean_v;
  logic [AXIS_W:0]          diff_v;
  logic [15:0]              spread_v;
  logic [1:0]               cls_v;
  logic [COUNT_BITS-1:0]    bad_sel;

  // ---------------- sample update ----------------
  always_comb begin
    logic same;
    logic take;
    logic signed [AXIS_W-1:0] v;
    good_nxt      = good_r;
    failed_nxt    = failed_r;
    zero_nxt      = zero_r;
    ones_nxt      = ones_r;
    stale_nxt     = stale_r;
    prev_nxt      = prev_r;
    have_prev_nxt = have_prev_r;
    failing_nxt   = failing_r;
    frozen_nxt    = frozen_r;
    flags_s       = '0;
    sum_nxt       = sum_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    same          = have_prev_r && (sample_r == prev_r);
    take          = !(&good_r);
    v             = '0;
    if (!read_ok_r) begin
      flags_s[FLG_FAILED] = 1'b1;
      failed_nxt          = sat_inc(failed_r);
      have_prev_nxt       = 1'b0;
      if (!failing_r) begin
        failing_nxt            = 1'b1;
        flags_s[FLG_FAILSTART] = 1'b1;
      end
    end else begin
      if (failing_r) begin
        failing_nxt            = 1'b0;
        flags_s[FLG_RECOVERED] = 1'b1;
      end
      if (sample_r == '0) begin
        flags_s[FLG_ALLZERO] = 1'b1;
        zero_nxt             = sat_inc(zero_r);
      end
      if (&sample_r) begin
        flags_s[FLG_ALLONES] = 1'b1;
        ones_nxt             = sat_inc(ones_r);
      end
      if (same) begin
        flags_s[FLG_FROZEN] = 1'b1;
        stale_nxt           = sat_inc(stale_r);
        if (!frozen_r) begin
          frozen_nxt               = 1'b1;
          flags_s[FLG_FROZENSTART] = 1'b1;
        end
      end else if (frozen_r) begin
        frozen_nxt            = 1'b0;
        flags_s[FLG_UNFROZEN] = 1'b1;
      end
      prev_nxt      = sample_r;
      have_prev_nxt = 1'b1;
      good_nxt      = sat_inc(good_r);
      for (int a = 0; a < AXES; a++) begin
        v = $signed(sample_r[a*AXIS_W +: AXIS_W]);
        if (take) sum_nxt[a] = sum_r[a] + SUM_W'(v);
        if (v < min_r[a]) min_nxt[a] = v;
        if (v > max_r[a]) max_nxt[a] = v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      noise_min_r <= 16'd2;
      noise_max_r <= 16'd200;
      good_r      <= '0;
      failed_r    <= '0;
      zero_r      <= '0;
      ones_r      <= '0;
      stale_r     <= '0;
      prev_r      <= '0;
      have_prev_r <= 1'b0;
      failing_r   <= 1'b0;
      frozen_r    <= 1'b0;
      for (int a = 0; a < AXES; a++) begin
        sum_r[a] <= '0;
        min_r[a] <= 16'sh7FFF;
        max_r[a] <= 16'sh8000;
      end
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_NOISE_MIN: noise_min_r <= cfg_data;
          REG_NOISE_MAX: noise_max_r <= cfg_data;
        endcase
      end
      if (cmd.do_sample) begin
        good_r      <= good_nxt;
        failed_r    <= failed_nxt;
        zero_r      <= zero_nxt;
        ones_r      <= ones_nxt;
        stale_r     <= stale_nxt;
        prev_r      <= prev_nxt;
        have_prev_r <= have_prev_nxt;
        failing_r   <= failing_nxt;
        frozen_r    <= frozen_nxt;
        sum_r       <= sum_nxt;
        min_r       <= min_nxt;
        max_r       <= max_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      read_ok_r <= in_tuser[1];
      sample_r  <= in_tdata;
    end
  end

  // ---------------- report ----------------
  assign sel_sum = sum_r[cmd.axis];
  assign sel_min = min_r[cmd.axis];
  assign sel_max = max_r[cmd.axis];
  assign sum_neg = sel_sum[SUM_W-1];
  assign sum_mag = sum_neg ? (~sel_sum + 1'b1) : sel_sum;

  sshm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (sum_mag[ABS_W-1:0]),
    .divisor  (good_r),
    .done     (div_done),
    .quotient (quotient)
  );

  assign q16      = quotient[AXIS_W-1:0];
  assign mean_v   = sum_neg ? (~q16 + 1'b1) : q16;
  assign diff_v   = {sel_max[AXIS_W-1], sel_max} - {sel_min[AXIS_W-1], sel_min};
  assign spread_v = diff_v[15:0];

  always_comb begin
    priority if (spread_v < noise_min_r) cls_v = CLS_QUIET;
    else if (spread_v > noise_max_r)     cls_v = CLS_NOISY;
    else                                 cls_v = CLS_NORMAL;
  end

  always_comb begin
    unique case (cmd.axis)
      AXIS_X:  bad_sel = zero_r;
      AXIS_Y:  bad_sel = ones_r;
      default: bad_sel = stale_r;
    endcase
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.do_sample || cmd.emit_report) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_sample) begin
      out_kind_r   <= KIND_STATUS;
      out_item_r   <= '0;
      out_last_r   <= 1'b1;
      out_flags_r  <= flags_s;
      out_mean_r   <= '0;
      out_min_r    <= '0;
      out_max_r    <= '0;
      out_spread_r <= '0;
      out_cls_r    <= CLS_NORMAL;
      out_ok_r     <= '0;
      out_fail_r   <= '0;
      out_bad_r    <= '0;
    end else if (cmd.emit_report) begin
      out_kind_r  <= KIND_REPORT;
      out_item_r  <= cmd.axis;
      out_last_r  <= (cmd.axis == AXIS_LAST);
      out_flags_r <= '0;
      out_ok_r    <= out16(good_r);
      out_fail_r  <= out16(failed_r);
      out_bad_r   <= out16(bad_sel);
      if (sts.no_good) begin
        out_mean_r   <= '0;
        out_min_r    <= '0;
        out_max_r    <= '0;
        out_spread_r <= '0;
        out_cls_r    <= CLS_EMPTY;
      end else begin
        out_mean_r   <= mean_v;
        out_min_r    <= sel_min;
        out_max_r    <= sel_max;
        out_spread_r <= spread_v;
        out_cls_r    <= cls_v;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = {out_item_r, out_kind_r};
  assign out_tdata  = {6'b0, out_bad_r, out_fail_r, out_ok_r, out_cls_r, out_spread_r,
                       out_max_r, out_min_r, out_mean_r, out_flags_r};

  assign sts.out_free = !out_valid_r || out_tready;
  assign sts.no_good  = (good_r == '0);
  assign sts.div_done = div_done;

  a_good_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> good_r >= $past(good_r))
    else $error("good sample total went backwards");

  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    (good_r != '0) |-> (min_r[0] <= max_r[0]) && (min_r[2] <= max_r[2]))
    else $error("axis min above max after a good sample");

endmodule
